@@ hw/rtl/ksme_pkg.sv @@
// ----------------------------------------------------------------------------
// ksme_pkg: shared types and constants of the SOS move engine
// Item kinds, register indexes, the ring size and the fixed-point widths used
// by the engine.
// ----------------------------------------------------------------------------
package ksme_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [0:0] REG_BETA  = 1'b0;
  localparam logic [0:0] REG_DRIVE = 1'b1;

  // The ring holds two cells per column; the column count is a power of two.
  localparam int Sites = 256;

  localparam int BetaW  = 24;
  localparam int DriveW = 20;
  localparam logic [BetaW-1:0]  BetaReset  = 24'd461427;
  localparam logic [DriveW-1:0] DriveReset = 20'd0;

endpackage

@@ hw/rtl/ksme_mul.sv @@
// ----------------------------------------------------------------------------
// ksme_mul: shared registered multiplier
// One 34x34 unsigned product, split into two 17-bit halves of the second operand.
// ----------------------------------------------------------------------------
module ksme_mul (
  input  logic        clk,
  input  logic        start,
  input  logic [33:0] op_a,
  input  logic [33:0] op_b,
  output logic [67:0] prod
);

  logic [33:0] a_r;
  logic [33:0] b_r;
  logic [50:0] lo_r;
  logic [50:0] hi_w;

  assign hi_w = 51'(a_r * b_r[33:17]);

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= op_a;
      b_r  <= op_b;
    end
    lo_r <= 51'(a_r * b_r[16:0]);
  end

  assign prod = {hi_w, 17'd0} + {17'd0, lo_r};

endmodule

@@ hw/rtl/kawasaki_sos_move_engine_core.sv @@
// ----------------------------------------------------------------------------
// kawasaki_sos_move_engine_core: Kawasaki SOS Metropolis move engine
// Holds a ring of occupancy cells, loads and reads cells and performs moves.
// ----------------------------------------------------------------------------
// Each word is handled alone: no new word is taken until the result of the last
// has left the output. After reset a clearing pass zeroes all 2*SITES (512)
// cells of the ring, one cell per cycle, during which no word is taken. A move
// reads ten cells through the single ring port, one per cycle, and is then
// rejected on an empty source or full destination, accepted without the
// exponential, or handed to the exponential. The exponential runs 14 steps
// through one shared multiplier. Output stalls hold the result until it is
// taken.
module kawasaki_sos_move_engine_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_kind,
  input  logic [8:0]            in_cell_index,
  input  logic [7:0]            in_cell_value,
  input  logic                  in_direction,
  input  logic [31:0]           in_random_fraction,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_accepted,
  output logic [7:0]            out_read_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam int Cells = 2 * ksme_pkg::Sites;
  localparam int AW = $clog2(Cells);
  localparam int CW = $clog2(ksme_pkg::Sites);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_GATHER, S_ENERGY, S_MUL, S_WRSRC, S_WRDST, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    X_EB, X_ZZ, X_T3, X_D3, X_T4, X_SQ, X_CMP
  } xstep_t;

  state_t state_r;
  xstep_t xs_r;
  logic [1:0] mcyc_r;
  logic [3:0] sq_r;
  logic [3:0] rd_r;
  logic [AW-1:0] clr_r;

  logic [7:0] ring [Cells];
  logic [7:0] rdata_r;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  logic [ksme_pkg::BetaW-1:0]  beta_r;
  logic [ksme_pkg::DriveW-1:0] drive_r;

  logic [AW-1:0] cell_r;
  logic [AW-1:0] dest_r;
  logic [7:0]    value_r;
  logic          up_r;
  logic [31:0]   rnd_r;
  logic [7:0]    src_v_r;
  logic [7:0]    dst_v_r;
  logic [8:0]    h_r [4];
  logic [7:0]    first_r;
  logic          acc_r;
  logic [7:0]    rv_r;
  logic [33:0]   emag_r;
  logic [33:0]   z_r;
  logic [33:0]   t2_r;
  logic [33:0]   t3_r;
  logic [33:0]   p_r;

  logic [AW:0] idx_ext;
  logic [AW-1:0] in_cell;

  logic        mstart;
  logic [33:0] ma;
  logic [33:0] mb;
  logic [67:0] prod;

  ksme_mul u_mul (
    .clk   (clk),
    .start (mstart),
    .op_a  (ma),
    .op_b  (mb),
    .prod  (prod)
  );

  always_comb begin
    idx_ext = (AW + 1)'({1'b0, in_cell_index} % 10'(Cells));
    in_cell = idx_ext[AW-1:0];
  end

  // Column address of the read sequence: cells of columns k-s, k+s, k+2s, k.
  function automatic logic [CW-1:0] col_of(input logic [CW-1:0] k, input logic up,
                                          input logic [1:0] off);
    logic [CW:0] d;
    begin
      d = (CW + 1)'(off == 2'd0 ? 1 : (off == 2'd1 ? 1 : (off == 2'd2 ? 2 : 0)));
      if (off == 2'd0) col_of = up ? CW'(k - d[CW-1:0]) : CW'(k + d[CW-1:0]);
      else col_of = up ? CW'(k + d[CW-1:0]) : CW'(k - d[CW-1:0]);
    end
  endfunction

  logic [CW-1:0] rcol;
  logic [3:0] rd_off;
  always_comb begin
    rd_off = 4'(rd_r - 4'd2);
    rcol = col_of(cell_r[AW-1:1], up_r, rd_off[2:1]);
    raddr = cell_r;
    if (state_r == S_IDLE) raddr = in_cell;
    else if (state_r == S_RD) begin
      if (rd_r == 4'd0) raddr = cell_r;
      else if (rd_r == 4'd1) raddr = dest_r;
      else raddr = {rcol, rd_r[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (we) ring[waddr] <= wdata;
    rdata_r <= ring[raddr];
  end

  always_comb begin
    we = 1'b0;
    waddr = cell_r;
    wdata = value_r;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr_r;
        wdata = 8'd0;
      end
      S_WRSRC: begin
        we = acc_r;
        wdata = 8'(src_v_r - 8'd1);
      end
      S_WRDST: begin
        we = acc_r;
        waddr = dest_r;
        wdata = 8'(dst_v_r + 8'd1);
      end
      S_IDLE: begin
        we = in_valid && ksme_pkg::kind_t'(in_kind) == ksme_pkg::KIND_WRITE;
        waddr = in_cell;
        wdata = in_cell_value;
      end
      default: ;
    endcase
  end

  function automatic logic [9:0] absd(input logic [10:0] v);
    begin
      absd = v[10] ? 10'(-v) : v[9:0];
    end
  endfunction

  logic signed [10:0] hx, hn, hp, hq;
  logic [10:0] a1, a2, a3, b1, b2, b3;
  logic signed [4:0] de;
  logic signed [37:0] e16;
  always_comb begin
    hn = 11'(h_r[0]);
    hp = 11'(h_r[1]);
    hq = 11'(h_r[2]);
    hx = 11'(h_r[3]);
    a1 = hx - 11'sd1 - hn;
    a2 = hx - hp - 11'sd2;
    a3 = hp + 11'sd1 - hq;
    b1 = hx - hn;
    b2 = hx - hp;
    b3 = hp - hq;
    de = 5'(11'(absd(a1)) + 11'(absd(a2)) + 11'(absd(a3))
         - 11'(absd(b1)) - 11'(absd(b2)) - 11'(absd(b3)));
    e16 = 38'(de) * 38'sd65536;
    if (!cell_r[0]) e16 = up_r ? e16 + 38'(drive_r) : e16 - 38'(drive_r);
  end

  always_comb begin
    ma = z_r;
    mb = z_r;
    mstart = (state_r == S_MUL) && (mcyc_r == 2'd0);
    unique case (xs_r)
      X_EB: begin
        ma = emag_r;
        mb = 34'(beta_r);
      end
      X_ZZ: begin
        ma = z_r;
        mb = z_r;
      end
      X_T3: begin
        ma = t2_r;
        mb = z_r;
      end
      X_D3: begin
        // Division by three as a product with the rounded-up reciprocal.
        ma = t3_r;
        mb = 34'h0_AAAA_AAAB;
      end
      X_T4: begin
        ma = t3_r;
        mb = z_r;
      end
      X_SQ: begin
        ma = p_r;
        mb = p_r;
      end
      default: ;
    endcase
  end

  logic [35:0] psum;
  always_comb begin
    psum = 36'h1_0000_0000 - 36'(z_r) + 36'(t2_r) - 36'(t3_r) + 36'(prod[67:34]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      beta_r  <= ksme_pkg::BetaReset;
      drive_r <= ksme_pkg::DriveReset;
      xs_r    <= X_EB;
      mcyc_r  <= '0;
      rd_r    <= '0;
      sq_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ksme_pkg::REG_BETA) beta_r <= cfg_data[ksme_pkg::BetaW-1:0];
        else drive_r <= cfg_data[ksme_pkg::DriveW-1:0];
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= AW'(clr_r + 1'b1);
          if (clr_r == AW'(Cells - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cell_r  <= in_cell;
            value_r <= in_cell_value;
            up_r    <= in_direction;
            rnd_r   <= in_random_fraction;
            dest_r  <= in_direction ? AW'(in_cell + AW'(2)) : AW'(in_cell - AW'(2));
            acc_r   <= 1'b0;
            rv_r    <= 8'd0;
            rd_r    <= '0;
            state_r <= in_kind == ksme_pkg::KIND_MOVE ? S_RD :
                       (in_kind == ksme_pkg::KIND_READ ? S_GATHER : S_OUT);
          end
        end
        S_GATHER: begin
          rv_r <= rdata_r;
          state_r <= S_OUT;
        end
        S_RD: begin
          rd_r <= 4'(rd_r + 1'b1);
          if (rd_r == 4'd1) src_v_r <= rdata_r;
          if (rd_r == 4'd2) dst_v_r <= rdata_r;
          if (rd_r >= 4'd3) begin
            if (rd_r[0]) first_r <= rdata_r;
            else h_r[2'((rd_r - 4'd4) >> 1)] <= 9'(first_r) + 9'(rdata_r);
          end
          if (rd_r == 4'd10) state_r <= S_ENERGY;
        end
        S_ENERGY: begin
          if (src_v_r == 8'd0 || dst_v_r == 8'd255) begin
            state_r <= S_OUT;
          end else if (e16 <= 0 || beta_r == '0) begin
            acc_r <= 1'b1;
            state_r <= S_WRSRC;
          end else begin
            emag_r <= 34'(e16);
            xs_r   <= X_EB;
            mcyc_r <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          mcyc_r <= 2'(mcyc_r + 1'b1);
          if (mcyc_r == 2'd2) begin
            mcyc_r <= '0;
            unique case (xs_r)
              X_EB: begin
                z_r <= 34'(prod[63:12]);
                if (prod[63:36] >= 28'd23) begin
                  state_r <= S_OUT;
                end else begin
                  xs_r <= X_ZZ;
                end
              end
              X_ZZ: begin
                t2_r <= 34'(prod[67:33]);
                xs_r <= X_T3;
              end
              X_T3: begin
                t3_r <= 34'(prod[67:32]);
                xs_r <= X_D3;
              end
              X_D3: begin
                t3_r <= 34'(prod[67:33]);
                xs_r <= X_T4;
              end
              X_T4: begin
                p_r  <= psum > 36'hFFFF_FFFF ? 34'hFFFF_FFFF : 34'(psum);
                sq_r <= '0;
                xs_r <= X_SQ;
              end
              X_SQ: begin
                p_r  <= 34'(prod[63:32]);
                sq_r <= 4'(sq_r + 1'b1);
                if (sq_r == 4'd7) xs_r <= X_CMP;
              end
              default: begin
                if (34'(rnd_r) < p_r) begin
                  acc_r <= 1'b1;
                  state_r <= S_WRSRC;
                end else begin
                  state_r <= S_OUT;
                end
              end
            endcase
          end
        end
        S_WRSRC: state_r <= S_WRDST;
        S_WRDST: state_r <= S_OUT;
        S_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (!out_stall) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_accepted = acc_r;
  assign out_read_value = rv_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT)
    else $error("result shown outside of the output state");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> state_r != S_IDLE)
    else $error("accepted word left no work");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_accepted && rv_r != 8'd0))
    else $error("move result carries a read value");

endmodule
